// ===== rtl/bpbcd_pkg.sv =====
// Shared constants and types for the binary to packed BCD converter.
package bpbcd_pkg;

  localparam int MAX_BYTES  = 10;
  localparam int VALUE_W    = 63;
  localparam int DIGITS     = 2 * MAX_BYTES;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int COUNT_W    = 4;
  localparam int INDEX_W    = 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_BYTES);

  typedef logic [BCD_W-1:0] bcd_t;

endpackage

// ===== rtl/binary_to_packed_bcd_top.sv =====
// Top level of the binary to packed BCD converter.
//
// Usage:
//   Configuration: write byte_count (1..10) on cfg_valid/cfg_ready while the
//   block is idle; cfg_ready is always high. Values above 10 saturate to 10,
//   zero makes a value produce no bytes at all. Reset sets byte_count to 4.
//   Input: one 63-bit request on in_value with in_valid/in_ready. in_ready is
//   high only while the converter is idle.
//   Output: byte_count result bytes per request, least significant first,
//   on out_bcd_byte/out_byte_index/out_last with out_valid/out_ready; out_last
//   marks the final byte of the run.
// Timing:
//   The shared double-dabble unit runs once per input bit; once the last bit
//   is shifted in, the first byte is loaded into the output register. Bytes
//   then leave at one per cycle while out_ready is high. A new request is
//   taken as soon as the last byte is loaded into the output register, even
//   while that byte still waits. When the receiver stalls the output register
//   holds its byte and the byte stream pauses. Reset (rst_n low, synchronous)
//   returns to idle and drops any pending output.
module binary_to_packed_bcd_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpbcd_pkg::COUNT_W-1:0]    cfg_byte_count,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bpbcd_pkg::VALUE_W-1:0]    in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_bcd_byte,
  output logic [bpbcd_pkg::INDEX_W-1:0]    out_byte_index,
  output logic                             out_last
);
  import bpbcd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [COUNT_W-1:0]   n_r, n_nxt;
  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  bcd_t                 bcd_r, bcd_nxt;
  bcd_t                 bcd_step;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [INDEX_W-1:0]   idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic [INDEX_W-1:0]   out_idx_r, out_idx_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 in_fire;
  logic                 out_free;
  logic                 idx_last;

  // Shared add-3 and shift unit, used once per input bit.
  bpbcd_dabble u_dabble (
    .bcd_in  (bcd_r),
    .bit_in  (bin_r[VALUE_W-1]),
    .bcd_out (bcd_step)
  );

  assign cfg_ready      = 1'b1;
  assign in_ready       = (state_r == S_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign idx_last       = (idx_r == n_r - COUNT_W'(1));

  assign out_valid      = out_valid_r;
  assign out_bcd_byte   = out_byte_r;
  assign out_byte_index = out_idx_r;
  assign out_last       = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    byte_count_nxt = byte_count_r;
    n_nxt          = n_r;
    bin_nxt        = bin_r;
    bcd_nxt        = bcd_r;
    bit_cnt_nxt    = bit_cnt_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;

    if (cfg_valid) begin
      byte_count_nxt = cfg_byte_count;
    end

    // Drop the output byte once the receiver takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // A zero byte count drops the request; stay idle.
        if (in_fire && (byte_count_r != '0)) begin
          n_nxt       = (byte_count_r > COUNT_MAX) ? COUNT_MAX : byte_count_r;
          bin_nxt     = in_value;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        // Advance one bit through the dabble unit.
        bcd_nxt     = bcd_step;
        bin_nxt     = {bin_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Load the next byte when the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = bcd_r[7:0];
          out_idx_nxt   = idx_r;
          out_last_nxt  = idx_last;
          bcd_nxt       = {8'h00, bcd_r[BCD_W-1:8]};
          idx_nxt       = idx_r + INDEX_W'(1);
          if (idx_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      byte_count_r <= COUNT_RESET;
      out_valid_r  <= 1'b0;
      bit_cnt_r    <= '0;
      idx_r        <= '0;
      n_r          <= COUNT_RESET;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      out_valid_r  <= out_valid_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== rtl/bpbcd_dabble.sv =====
// One double-dabble step: add-3 correction on every digit, then shift in one bit.
module bpbcd_dabble (
  input  bpbcd_pkg::bcd_t bcd_in,
  input  logic            bit_in,
  output bpbcd_pkg::bcd_t bcd_out
);
  import bpbcd_pkg::*;

  bcd_t adj;

  // Correct each digit independently before the shift.
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_in[4*d +: 4] > 4'd4) begin
        adj[4*d +: 4] = bcd_in[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd_in[4*d +: 4];
      end
    end
  end

  assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule

// ===== rtl/bpbcd_checker.sv =====
// Port-level assertions for the binary to packed BCD converter, with bind.
module bpbcd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [7:0]                    out_bcd_byte,
  input logic [bpbcd_pkg::INDEX_W-1:0] out_byte_index,
  input logic                          out_last
);
  import bpbcd_pkg::*;

  // Hold a stalled byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bcd_byte)
      && $stable(out_byte_index) && $stable(out_last))
    else $error("stalled output byte changed");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bcd_byte[3:0] <= 4'd9) && (out_bcd_byte[7:4] <= 4'd9))
    else $error("output nibble is not a decimal digit");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_index < INDEX_W'(MAX_BYTES)))
    else $error("byte index out of range");

  // Mid-run the converter must not take a new request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request accepted in the middle of a byte run");

endmodule

bind binary_to_packed_bcd_top bpbcd_checker u_bpbcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_bcd_byte   (out_bcd_byte),
  .out_byte_index (out_byte_index),
  .out_last       (out_last)
);
